### rtl/core/lbst_pkg.sv
// Package for the lamp board status table.
// Holds the input and result word types and the fixed frame codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbst_pkg;

    typedef struct packed {
        logic        operation;
        logic [31:0] can_id;
        logic [7:0]  payload_byte0;
        logic [7:0]  payload_byte1;
        logic [7:0]  payload_byte2;
        logic [7:0]  payload_byte3;
        logic [7:0]  payload_byte4;
        logic [7:0]  payload_byte5;
        logic [5:0]  query_channel;
    } t_in_word;

    typedef struct packed {
        logic [1:0] frame_class;
        logic       query_valid;
        logic [2:0] voltage_code;
        logic [7:0] red_current;
    } t_out_word;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] CLS_NONE      = 2'd0;
    localparam logic [1:0] CLS_LAMP      = 2'd1;
    localparam logic [1:0] CLS_BAD_BOARD = 2'd2;
    localparam logic [1:0] CLS_DETECTOR  = 2'd3;

    localparam logic [21:0] LAMP_ID_FLOOR = 22'h200000;
    localparam int unsigned LAMP_FLAG_BIT = 21;
    localparam logic [31:0] DETECTOR_ID_A = 32'h0000_0201;
    localparam logic [31:0] DETECTOR_ID_B = 32'h0000_0202;

    localparam int unsigned VCODE_BITS = 3;
    localparam int unsigned VWORD_BITS = 18;
    localparam int unsigned FRAME_BYTES = 6;

endpackage

`default_nettype wire

### rtl/core/lamp_board_status_table.sv
// Lamp board status table: stores lamp feedback frames per board and
// answers per-channel status queries. Uses lbst_pkg for word types and codes.
// Single module; no submodules.
//
// One word in, one word out. A frame word with a lamp feedback identifier
// (low 22 bits above 0x200000, bit 21 set) writes the voltage codes and
// currents of the board named in identifier bits 2..0; identifiers 0x201
// and 0x202 are only flagged as vehicle detector frames. A query word reads
// one channel (1 to MAX_CHANNELS) back. Each word is decoded and the table is
// read or written in the cycle it is accepted, and its result sits in the
// output register on the next cycle. One word per cycle is taken as long as
// the output register is empty or being drained; o_in_stall follows
// i_out_stall while a result is held. A frame is visible to a query
// accepted in the next cycle. The table is cleared by reset.
`timescale 1ns / 1ps
`default_nettype none

module lamp_board_status_table #(
    parameter int BOARDS             = 6,
    parameter int CHANNELS_PER_BOARD = 6,
    parameter int MAX_CHANNELS       = 36
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  lbst_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output lbst_pkg::t_out_word o_out_data
);

    localparam int BIW = (BOARDS > 1) ? $clog2(BOARDS) : 1;
    localparam int PIW = (CHANNELS_PER_BOARD > 1) ? $clog2(CHANNELS_PER_BOARD) : 1;

    logic [lbst_pkg::VWORD_BITS-1:0]          r_volt [BOARDS];
    logic [CHANNELS_PER_BOARD-1:0][7:0]       r_curr [BOARDS];

    logic                r_out_valid;
    lbst_pkg::t_out_word r_out;
    lbst_pkg::t_out_word n_out;

    logic           w_accept;
    logic           w_is_lamp;
    logic           w_store;
    logic [2:0]     w_board_num;
    logic [BIW-1:0] w_wr_idx;
    logic [7:0]     w_bytes [lbst_pkg::FRAME_BYTES];

    logic [5:0]     w_chm1;
    logic           w_found;
    logic [BIW-1:0] w_rd_idx;
    logic [PIW-1:0] w_pos;
    logic           w_qvalid;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_bytes[0] = i_in_data.payload_byte0;
    assign w_bytes[1] = i_in_data.payload_byte1;
    assign w_bytes[2] = i_in_data.payload_byte2;
    assign w_bytes[3] = i_in_data.payload_byte3;
    assign w_bytes[4] = i_in_data.payload_byte4;
    assign w_bytes[5] = i_in_data.payload_byte5;

    // frame decode
    assign w_is_lamp   = (i_in_data.can_id[21:0] > lbst_pkg::LAMP_ID_FLOOR)
                       & i_in_data.can_id[lbst_pkg::LAMP_FLAG_BIT];
    assign w_board_num = i_in_data.can_id[2:0];
    assign w_store     = (i_in_data.operation == lbst_pkg::OP_FRAME) & w_is_lamp
                       & (w_board_num != 3'd0) & ({1'b0, w_board_num} <= 4'(BOARDS));
    assign w_wr_idx    = BIW'(w_board_num - 3'd1);

    // query decode: board and position by range compare per board
    assign w_chm1 = i_in_data.query_channel - 6'd1;

    always_comb begin
        w_found  = 1'b0;
        w_rd_idx = '0;
        w_pos    = '0;
        for (int b = 0; b < BOARDS; b++) begin
            if ({1'b0, w_chm1} >= 7'(b * CHANNELS_PER_BOARD)
                && {1'b0, w_chm1} < 7'((b + 1) * CHANNELS_PER_BOARD)) begin
                w_found  = 1'b1;
                w_rd_idx = BIW'(b);
                w_pos    = PIW'(w_chm1 - 6'(b * CHANNELS_PER_BOARD));
            end
        end
    end

    assign w_qvalid = (i_in_data.query_channel != 6'd0)
                    & ({1'b0, i_in_data.query_channel} <= 7'(MAX_CHANNELS))
                    & w_found;

    always_comb begin
        n_out = '0;
        if (i_in_data.operation == lbst_pkg::OP_FRAME) begin
            if (w_is_lamp) begin
                n_out.frame_class = w_store ? lbst_pkg::CLS_LAMP : lbst_pkg::CLS_BAD_BOARD;
            end else if (i_in_data.can_id == lbst_pkg::DETECTOR_ID_A
                         || i_in_data.can_id == lbst_pkg::DETECTOR_ID_B) begin
                n_out.frame_class = lbst_pkg::CLS_DETECTOR;
            end else begin
                n_out.frame_class = lbst_pkg::CLS_NONE;
            end
        end else if (w_qvalid) begin
            n_out.query_valid  = 1'b1;
            n_out.voltage_code =
                r_volt[w_rd_idx][lbst_pkg::VCODE_BITS * w_pos +: lbst_pkg::VCODE_BITS];
            n_out.red_current  = r_curr[w_rd_idx][w_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BOARDS; b++) begin
                r_volt[b] <= '0;
                for (int k = 0; k < CHANNELS_PER_BOARD; k++) begin
                    r_curr[b][k] <= '0;
                end
            end
        end else if (w_accept && w_store) begin
            r_volt[w_wr_idx] <= i_in_data.can_id[20:3];
            for (int k = 0; k < CHANNELS_PER_BOARD; k++) begin
                r_curr[w_wr_idx][k] <= w_bytes[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid)
        else $error("input stalled with no result held");

    a_frame_no_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_class != lbst_pkg::CLS_NONE) |->
        (!r_out.query_valid && r_out.voltage_code == '0 && r_out.red_current == '0))
        else $error("frame result carries query fields");

    a_invalid_query_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.query_valid) |->
        (r_out.voltage_code == '0 && r_out.red_current == '0))
        else $error("out-of-range query returned data");

    a_store_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_store) |=>
        (r_volt[$past(w_wr_idx)] == $past(i_in_data.can_id[20:3])
         && r_out.frame_class == lbst_pkg::CLS_LAMP))
        else $error("lamp frame not stored");
`endif

endmodule

`default_nettype wire

### tb/lamp_board_status_table_test.sv
// Testbench for lamp_board_status_table: a directed table and then random frame and
// query words, with each result checked against the row's fixed result or an in-bench
// model of the board table. Depends on lbst_pkg and lamp_board_status_table.
`timescale 1ns / 1ps

module lamp_board_status_table_test;

    localparam int N_BOARDS     = 6;
    localparam int CH_PER_BOARD = 6;
    localparam int N_CHANNELS   = 36;
    localparam int RAND_WORDS   = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        lbst_pkg::t_in_word  word;
        bit                  fixed;
        lbst_pkg::t_out_word result;
    } t_dir_row;

    logic                i_clk;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    lbst_pkg::t_in_word  in_data  = '0;
    logic                out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    lbst_pkg::t_out_word o_out_data;

    // Fixed result for the current directed row, if it has one
    bit                  in_fixed  = 1'b0;
    lbst_pkg::t_out_word in_result = '0;
    bit                  quiet     = 1'b0;

    logic [lbst_pkg::VWORD_BITS-1:0] board_vword [N_BOARDS];
    logic [7:0]                      chan_current [N_BOARDS*CH_PER_BOARD];
    lbst_pkg::t_out_word             pending_status_q [$];
    t_dir_row                        dir_rows [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int stall_left     = 0;
    int n_stored = 0, n_bad = 0, n_detector = 0, n_ignored = 0;
    int n_query = 0, n_query_hit = 0;

    lamp_board_status_table #(
        .BOARDS             (N_BOARDS),
        .CHANNELS_PER_BOARD (CH_PER_BOARD),
        .MAX_CHANNELS       (N_CHANNELS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        for (int b = 0; b < N_BOARDS; b++) board_vword[b] = '0;
        for (int c = 0; c < N_BOARDS*CH_PER_BOARD; c++) chan_current[c] = '0;
    end

    function automatic lbst_pkg::t_out_word predict_status(input lbst_pkg::t_in_word w);
        lbst_pkg::t_out_word r;
        logic [7:0]          bytes [6];
        logic [2:0]          board;
        int                  ch;
        int                  bd;
        int                  pos;
        r = '0;
        if (w.operation == lbst_pkg::OP_FRAME) begin
            board = w.can_id[2:0];
            if (w.can_id[21:0] > lbst_pkg::LAMP_ID_FLOOR
                && w.can_id[lbst_pkg::LAMP_FLAG_BIT]) begin
                if (board == 0 || board > N_BOARDS) begin
                    r.frame_class = lbst_pkg::CLS_BAD_BOARD;
                end else begin
                    bytes = '{w.payload_byte0, w.payload_byte1, w.payload_byte2,
                              w.payload_byte3, w.payload_byte4, w.payload_byte5};
                    board_vword[board-1] = w.can_id[20:3];
                    for (int k = 0; k < CH_PER_BOARD && k < lbst_pkg::FRAME_BYTES; k++)
                        chan_current[(board-1)*CH_PER_BOARD + k] = bytes[k];
                    r.frame_class = lbst_pkg::CLS_LAMP;
                end
            end else if (w.can_id == lbst_pkg::DETECTOR_ID_A
                         || w.can_id == lbst_pkg::DETECTOR_ID_B) begin
                r.frame_class = lbst_pkg::CLS_DETECTOR;
            end
        end else begin
            ch = int'(w.query_channel);
            if (ch >= 1 && ch <= N_CHANNELS) begin
                bd  = (ch - 1) / CH_PER_BOARD;
                pos = (ch - 1) % CH_PER_BOARD;
                if (bd < N_BOARDS) begin
                    r.query_valid  = 1'b1;
                    r.voltage_code =
                        board_vword[bd][pos*lbst_pkg::VCODE_BITS +: lbst_pkg::VCODE_BITS];
                    r.red_current  = chan_current[bd*CH_PER_BOARD + pos];
                end
            end
        end
        return r;
    endfunction

    function automatic lbst_pkg::t_in_word frame_word(input logic [31:0] id,
                                                      input logic [7:0] b0,
                                                      input logic [7:0] b1,
                                                      input logic [7:0] b2,
                                                      input logic [7:0] b3,
                                                      input logic [7:0] b4,
                                                      input logic [7:0] b5);
        lbst_pkg::t_in_word w;
        w.operation     = lbst_pkg::OP_FRAME;
        w.can_id        = id;
        w.payload_byte0 = b0;
        w.payload_byte1 = b1;
        w.payload_byte2 = b2;
        w.payload_byte3 = b3;
        w.payload_byte4 = b4;
        w.payload_byte5 = b5;
        w.query_channel = 6'($urandom_range(0, 63));
        return w;
    endfunction

    function automatic lbst_pkg::t_in_word query_word(input logic [5:0] ch);
        lbst_pkg::t_in_word w;
        w = frame_word($urandom, 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom));
        w.operation     = lbst_pkg::OP_QUERY;
        w.query_channel = ch;
        return w;
    endfunction

    function automatic lbst_pkg::t_out_word status_word(input logic [1:0] cls,
                                                        input logic qv,
                                                        input logic [2:0] code,
                                                        input logic [7:0] cur);
        lbst_pkg::t_out_word r;
        r.frame_class  = cls;
        r.query_valid  = qv;
        r.voltage_code = code;
        r.red_current  = cur;
        return r;
    endfunction

    function automatic lbst_pkg::t_in_word random_word();
        lbst_pkg::t_in_word w;
        int                 sel;
        sel = $urandom_range(0, 99);
        w = frame_word($urandom, 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), 8'($urandom));
        if (sel < 40) begin
            w.can_id[lbst_pkg::LAMP_FLAG_BIT] = 1'b1;
            w.can_id[2:0] = (sel < 34) ? 3'($urandom_range(1, N_BOARDS))
                                       : 3'($urandom_range(0, 7));
        end else if (sel < 75) begin
            w.operation     = lbst_pkg::OP_QUERY;
            w.query_channel = (sel < 68) ? 6'($urandom_range(1, N_CHANNELS))
                                         : 6'($urandom_range(0, 63));
        end else if (sel < 85) begin
            w.can_id = $urandom_range(0, 1) ? lbst_pkg::DETECTOR_ID_A
                                            : lbst_pkg::DETECTOR_ID_B;
        end
        return w;
    endfunction

    task automatic log_mismatch(input string what, input lbst_pkg::t_out_word want,
                                input lbst_pkg::t_out_word got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display({"ERROR %s: expected class %0d qv %0d code %0d cur %0h, ",
                      "got class %0d qv %0d code %0d cur %0h"},
                     what, want.frame_class, want.query_valid, want.voltage_code,
                     want.red_current, got.frame_class, got.query_valid,
                     got.voltage_code, got.red_current);
    endtask

    task automatic send_word(input lbst_pkg::t_in_word w, input bit fixed,
                             input lbst_pkg::t_out_word result);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid  <= 1'b1;
        in_data   <= w;
        in_fixed  <= fixed;
        in_result <= result;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Result checker and input word tracker
    always @(posedge i_clk) begin
        lbst_pkg::t_out_word want;
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (pending_status_q.size() == 0) begin
                    log_mismatch("result with none pending", '0, o_out_data);
                end else begin
                    want = pending_status_q.pop_front();
                    if (want.frame_class  !== o_out_data.frame_class  ||
                        want.query_valid  !== o_out_data.query_valid  ||
                        want.voltage_code !== o_out_data.voltage_code ||
                        want.red_current  !== o_out_data.red_current)
                        log_mismatch("result", want, o_out_data);
                end
            end
            if (in_valid && !o_in_stall) begin
                want = predict_status(in_data);
                if (in_data.operation == lbst_pkg::OP_QUERY) begin
                    n_query++;
                    if (want.query_valid) n_query_hit++;
                end else begin
                    unique case (want.frame_class)
                        lbst_pkg::CLS_LAMP:      n_stored++;
                        lbst_pkg::CLS_BAD_BOARD: n_bad++;
                        lbst_pkg::CLS_DETECTOR:  n_detector++;
                        default:                 n_ignored++;
                    endcase
                end
                pending_status_q.push_back(in_fixed ? in_result : want);
            end
        end
    end

    // Receiver: randomly holds off results with out_stall, except in quiet phases
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            out_stall <= 1'b0;
            if (o_out_valid) stall_left = quiet ? 0 : $urandom_range(0, 6);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        dir_rows.push_back('{query_word(1), 1'b1,
                             status_word(lbst_pkg::CLS_NONE, 1'b1, 3'd0, 8'h00)});
        dir_rows.push_back('{query_word(0), 1'b1,
                             status_word(lbst_pkg::CLS_NONE, 1'b0, 3'd0, 8'h00)});
        dir_rows.push_back('{query_word(36), 1'b1,
                             status_word(lbst_pkg::CLS_NONE, 1'b1, 3'd0, 8'h00)});
        dir_rows.push_back('{query_word(37), 1'b1,
                             status_word(lbst_pkg::CLS_NONE, 1'b0, 3'd0, 8'h00)});
        dir_rows.push_back('{query_word(63), 1'b1,
                             status_word(lbst_pkg::CLS_NONE, 1'b0, 3'd0, 8'h00)});
        dir_rows.push_back('{frame_word(lbst_pkg::DETECTOR_ID_A, 1, 2, 3, 4, 5, 6), 1'b1,
                             status_word(lbst_pkg::CLS_DETECTOR, 1'b0, 3'd0, 8'h00)});
        dir_rows.push_back('{frame_word(lbst_pkg::DETECTOR_ID_B, 6, 5, 4, 3, 2, 1), 1'b1,
                             status_word(lbst_pkg::CLS_DETECTOR, 1'b0, 3'd0, 8'h00)});
        // lamp floor itself is not a lamp frame
        dir_rows.push_back('{frame_word(32'h0020_0000, 9, 9, 9, 9, 9, 9), 1'b1,
                             status_word(lbst_pkg::CLS_NONE, 1'b0, 3'd0, 8'h00)});
        // detector id with upper bits set is not a detector frame
        dir_rows.push_back('{frame_word(32'hFFC0_0201, 7, 7, 7, 7, 7, 7), 1'b1,
                             status_word(lbst_pkg::CLS_NONE, 1'b0, 3'd0, 8'h00)});
        dir_rows.push_back('{frame_word(32'h0010_0003, 8, 8, 8, 8, 8, 8), 1'b1,
                             status_word(lbst_pkg::CLS_NONE, 1'b0, 3'd0, 8'h00)});
        dir_rows.push_back('{frame_word(32'hFFFF_FFF9, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                        8'hFF), 1'b1,
                             status_word(lbst_pkg::CLS_LAMP, 1'b0, 3'd0, 8'h00)});
        dir_rows.push_back('{frame_word(32'h003F_FFFF, 1, 1, 1, 1, 1, 1), 1'b1,
                             status_word(lbst_pkg::CLS_BAD_BOARD, 1'b0, 3'd0, 8'h00)});
        dir_rows.push_back('{frame_word(32'h0020_0008, 2, 2, 2, 2, 2, 2), 1'b1,
                             status_word(lbst_pkg::CLS_BAD_BOARD, 1'b0, 3'd0, 8'h00)});
        dir_rows.push_back('{frame_word(32'h0020_0006, 0, 0, 0, 0, 0, 0), 1'b1,
                             status_word(lbst_pkg::CLS_LAMP, 1'b0, 3'd0, 8'h00)});
        dir_rows.push_back('{query_word(1), 1'b1,
                             status_word(lbst_pkg::CLS_NONE, 1'b1, 3'd7, 8'hFF)});
        dir_rows.push_back('{query_word(6), 1'b1,
                             status_word(lbst_pkg::CLS_NONE, 1'b1, 3'd7, 8'hFF)});
        dir_rows.push_back('{query_word(31), 1'b1,
                             status_word(lbst_pkg::CLS_NONE, 1'b1, 3'd0, 8'h00)});
        dir_rows.push_back('{frame_word({10'h3A5, 1'b1, 18'o765432, 3'd3}, 8'h11, 8'h22,
                                        8'h33, 8'h44, 8'h55, 8'h66), 1'b0, '0});
        for (int ch = 13; ch <= 18; ch++)
            dir_rows.push_back('{query_word(6'(ch)), 1'b0, '0});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].result);

        for (int i = 0; i < RAND_WORDS; i++) begin
            quiet = ((i / 50) % 4 == 3);
            send_word(random_word(), 1'b0, '0);
        end
        quiet = 1'b0;
        @(negedge i_clk);
        in_valid <= 1'b0;

        while (pending_status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (pending_status_q.size() != 0) mismatch_count++;

        $display("Sent %0d frames: %0d stored, %0d bad board, %0d detector, %0d ignored",
                 n_stored + n_bad + n_detector + n_ignored, n_stored, n_bad, n_detector,
                 n_ignored);
        $display("Sent %0d queries, %0d in range; %0d mismatches", n_query, n_query_hit,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
rtl/core/lbst_pkg.sv
rtl/core/lamp_board_status_table.sv
tb/lamp_board_status_table_test.sv
